// ----- hw/rtl/rti_pkg.sv -----
// Shared types and constants for the ray/triangle intersection unit.
// No dependencies; imported by rti_div_pipe and ray_triangle_intersect_unit.
`default_nettype none

package rti_pkg;

    // Default fraction bits of the Q format
    localparam int FRAC_BITS_DEF = 16;

    // Quotient magnitudes are clamped to 2^QCLAMP_LOG2
    localparam int QCLAMP_LOG2 = 40;
    localparam int QUOT_BITS   = QCLAMP_LOG2 + 1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ORIGIN_X     = 3'd0,
        CFG_ORIGIN_Y     = 3'd1,
        CFG_ORIGIN_Z     = 3'd2,
        CFG_DIR_X        = 3'd3,
        CFG_DIR_Y        = 3'd4,
        CFG_DIR_Z        = 3'd5,
        CFG_MAX_DISTANCE = 3'd6,
        CFG_EPSILON      = 3'd7
    } cfg_idx_t;

    // Result codes
    typedef enum logic [2:0] {
        REASON_HIT      = 3'd0,
        REASON_PARALLEL = 3'd1,
        REASON_U_OUT    = 3'd2,
        REASON_V_OUT    = 3'd3,
        REASON_DIST_OUT = 3'd4
    } miss_reason_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rti_div_pipe.sv -----
// Pipelined restoring divider: one quotient bit per stage, QW stages.
// Depends on rti_pkg; stage enables come from the top level's ready chain.
`default_nettype none

module rti_div_pipe
    import rti_pkg::*;
#(
    parameter int NW = 118,          // numerator magnitude width
    parameter int DW = 102,          // denominator magnitude width
    parameter int QW = QUOT_BITS     // quotient bits produced
) (
    input  wire logic          aclk,
    input  wire logic [QW-1:0] en,
    input  wire logic [NW-1:0] num_i,
    input  wire logic [DW-1:0] den_i,
    input  wire logic          neg_i,
    input  wire logic          ovf_i,
    output logic      [QW-1:0] q_o,
    output logic               neg_o,
    output logic               ovf_o
);

    // Stage sources: index 0 is the input, index k+1 is stage k's register
    logic [DW-1:0] p_src   [QW+1];
    logic [QW-1:0] l_src   [QW+1];
    logic [QW-1:0] q_src   [QW+1];
    logic [DW-1:0] den_src [QW+1];
    logic          neg_src [QW+1];
    logic          ovf_src [QW+1];

    logic [DW-1:0] p_reg   [QW];
    logic [QW-1:0] l_reg   [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [DW-1:0] den_reg [QW];
    logic          neg_reg [QW];
    logic          ovf_reg [QW];

    // Partial remainder starts with the numerator bits above the quotient range
    assign p_src[0]   = DW'(num_i[NW-1:QW]);
    assign l_src[0]   = num_i[QW-1:0];
    assign q_src[0]   = '0;
    assign den_src[0] = den_i;
    assign neg_src[0] = neg_i;
    assign ovf_src[0] = ovf_i;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] p_next;

        // Shift in one numerator bit, subtract when it fits
        always_comb begin
            trial  = {p_src[k], l_src[k][QW-1]};
            diff   = trial - {1'b0, den_src[k]};
            ge     = trial >= {1'b0, den_src[k]};
            p_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                p_reg[k]   <= p_next;
                l_reg[k]   <= {l_src[k][QW-2:0], 1'b0};
                q_reg[k]   <= {q_src[k][QW-2:0], ge};
                den_reg[k] <= den_src[k];
                neg_reg[k] <= neg_src[k];
                ovf_reg[k] <= ovf_src[k];
            end
        end

        assign p_src[k+1]   = p_reg[k];
        assign l_src[k+1]   = l_reg[k];
        assign q_src[k+1]   = q_reg[k];
        assign den_src[k+1] = den_reg[k];
        assign neg_src[k+1] = neg_reg[k];
        assign ovf_src[k+1] = ovf_reg[k];
    end

    assign q_o   = q_src[QW];
    assign neg_o = neg_src[QW];
    assign ovf_o = ovf_src[QW];

endmodule

`default_nettype wire

// ----- hw/rtl/ray_triangle_intersect_unit.sv -----
// From input transfer to result: front stages, the dividers, then the result, check and output stages.
// Throughput: one triangle per cycle while the output is not stalled; the 41-stage quotient dividers set the depth.
// Stalls collapse bubbles; s_ready drops only when every stage holds an item.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// register defaults: origin 0, direction +x unit, max distance 2^31-1, epsilon 1.
`default_nettype none

module ray_triangle_intersect_unit
    import rti_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration writes
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [31:0]        cfg_wr_data,
    // triangle input
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_v0_x,
    input  wire logic signed [31:0] s_v0_y,
    input  wire logic signed [31:0] s_v0_z,
    input  wire logic signed [31:0] s_v1_x,
    input  wire logic signed [31:0] s_v1_y,
    input  wire logic signed [31:0] s_v1_z,
    input  wire logic signed [31:0] s_v2_x,
    input  wire logic signed [31:0] s_v2_y,
    input  wire logic signed [31:0] s_v2_z,
    // result output
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_hit,
    output logic [2:0]              m_miss_reason,
    output logic [30:0]             m_distance,
    output logic signed [31:0]      m_point_x,
    output logic signed [31:0]      m_point_y,
    output logic signed [31:0]      m_point_z
);

    localparam int CW    = 32;                 // coordinate width
    localparam int EW    = CW + 1;             // edge / offset width
    localparam int PW    = 2 * EW;             // cross product term width
    localparam int HW    = PW + 1;             // cross product width
    localparam int SPL   = 34;                 // split point of the wide operand
    localparam int LOW   = EW + SPL + 1;       // low partial product width
    localparam int HIW   = EW + HW - SPL;      // high partial product width
    localparam int DOTW  = EW + HW + 2;        // dot product width
    localparam int NW    = DOTW + FRAC_BITS;   // scaled numerator width
    localparam int QW    = QUOT_BITS;
    localparam int RW    = QW + 1;             // signed quotient width
    localparam int MW    = 2 * CW;             // dir * t width
    localparam int SUMW  = MW + 1;
    localparam int PRE   = 8;
    localparam int ST_RES = PRE + QW;
    localparam int ST_CHK = ST_RES + 1;
    localparam int ST_OUT = ST_CHK + 1;
    localparam int NS     = ST_OUT + 1;

    localparam logic [QW-1:0]          QCLAMP  = QW'(1) << QCLAMP_LOG2;
    localparam logic signed [RW-1:0]   ONE_Q   = RW'(1) << FRAC_BITS;
    localparam logic signed [SUMW-1:0] SAT_MAX = (SUMW'(1) << (CW - 1)) - SUMW'(1);
    localparam logic signed [SUMW-1:0] SAT_MIN = -(SUMW'(1) << (CW - 1));

    // ------------------------------------------------------------------
    // Configuration registers
    logic signed [CW-1:0] origin_reg [3];
    logic signed [CW-1:0] dir_reg    [3];
    logic [30:0]          max_distance_reg;
    logic [15:0]          epsilon_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg[0]    <= '0;
            origin_reg[1]    <= '0;
            origin_reg[2]    <= '0;
            dir_reg[0]       <= CW'(1) << FRAC_BITS;
            dir_reg[1]       <= '0;
            dir_reg[2]       <= '0;
            max_distance_reg <= 31'h7FFF_FFFF;
            epsilon_reg      <= 16'd1;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_ORIGIN_X:     origin_reg[0]    <= cfg_wr_data;
                CFG_ORIGIN_Y:     origin_reg[1]    <= cfg_wr_data;
                CFG_ORIGIN_Z:     origin_reg[2]    <= cfg_wr_data;
                CFG_DIR_X:        dir_reg[0]       <= cfg_wr_data;
                CFG_DIR_Y:        dir_reg[1]       <= cfg_wr_data;
                CFG_DIR_Z:        dir_reg[2]       <= cfg_wr_data;
                CFG_MAX_DISTANCE: max_distance_reg <= cfg_wr_data[30:0];
                CFG_EPSILON:      epsilon_reg      <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // Direction at edge width for the products
    logic signed [EW-1:0] dir_e [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dir_e[i] = EW'(dir_reg[i]);
        end
    end

    // ------------------------------------------------------------------
    // Valid bits and ready chain
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] stage_rdy;

    always_comb begin
        stage_rdy[NS-1] = !valid_reg[NS-1] || m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_rdy[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (stage_rdy[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_ready = stage_rdy[0];
    assign m_valid = valid_reg[NS-1];

    // ------------------------------------------------------------------
    // Stage 0: edges and origin offset
    logic signed [CW-1:0] v0_in [3];
    logic signed [CW-1:0] v1_in [3];
    logic signed [CW-1:0] v2_in [3];
    assign v0_in[0] = s_v0_x;
    assign v0_in[1] = s_v0_y;
    assign v0_in[2] = s_v0_z;
    assign v1_in[0] = s_v1_x;
    assign v1_in[1] = s_v1_y;
    assign v1_in[2] = s_v1_z;
    assign v2_in[0] = s_v2_x;
    assign v2_in[1] = s_v2_y;
    assign v2_in[2] = s_v2_z;

    logic signed [EW-1:0] e1_s0_reg [3];
    logic signed [EW-1:0] e2_s0_reg [3];
    logic signed [EW-1:0] sv_s0_reg [3];

    always_ff @(posedge aclk) begin
        if (stage_rdy[0]) begin
            for (int i = 0; i < 3; i++) begin
                e1_s0_reg[i] <= EW'(v1_in[i]) - EW'(v0_in[i]);
                e2_s0_reg[i] <= EW'(v2_in[i]) - EW'(v0_in[i]);
                sv_s0_reg[i] <= EW'(origin_reg[i]) - EW'(v0_in[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: cross product terms, h = dir x e2 and q = s x e1
    logic signed [PW-1:0] hp_s1_reg [6];
    logic signed [PW-1:0] qp_s1_reg [6];
    logic signed [EW-1:0] e1_s1_reg [3];
    logic signed [EW-1:0] e2_s1_reg [3];
    logic signed [EW-1:0] sv_s1_reg [3];

    always_ff @(posedge aclk) begin
        if (stage_rdy[1]) begin
            hp_s1_reg[0] <= dir_e[1] * e2_s0_reg[2];
            hp_s1_reg[1] <= dir_e[2] * e2_s0_reg[1];
            hp_s1_reg[2] <= dir_e[2] * e2_s0_reg[0];
            hp_s1_reg[3] <= dir_e[0] * e2_s0_reg[2];
            hp_s1_reg[4] <= dir_e[0] * e2_s0_reg[1];
            hp_s1_reg[5] <= dir_e[1] * e2_s0_reg[0];
            qp_s1_reg[0] <= sv_s0_reg[1] * e1_s0_reg[2];
            qp_s1_reg[1] <= sv_s0_reg[2] * e1_s0_reg[1];
            qp_s1_reg[2] <= sv_s0_reg[2] * e1_s0_reg[0];
            qp_s1_reg[3] <= sv_s0_reg[0] * e1_s0_reg[2];
            qp_s1_reg[4] <= sv_s0_reg[0] * e1_s0_reg[1];
            qp_s1_reg[5] <= sv_s0_reg[1] * e1_s0_reg[0];
            e1_s1_reg    <= e1_s0_reg;
            e2_s1_reg    <= e2_s0_reg;
            sv_s1_reg    <= sv_s0_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cross product differences
    logic signed [HW-1:0] h_s2_reg  [3];
    logic signed [HW-1:0] q_s2_reg  [3];
    logic signed [EW-1:0] e1_s2_reg [3];
    logic signed [EW-1:0] e2_s2_reg [3];
    logic signed [EW-1:0] sv_s2_reg [3];

    always_ff @(posedge aclk) begin
        if (stage_rdy[2]) begin
            for (int i = 0; i < 3; i++) begin
                h_s2_reg[i] <= HW'(hp_s1_reg[2*i]) - HW'(hp_s1_reg[2*i+1]);
                q_s2_reg[i] <= HW'(qp_s1_reg[2*i]) - HW'(qp_s1_reg[2*i+1]);
            end
            e1_s2_reg <= e1_s1_reg;
            e2_s2_reg <= e2_s1_reg;
            sv_s2_reg <= sv_s1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: split partial products of the four dot products
    // dot 0: det = e1.h, 1: u num = s.h, 2: v num = dir.q, 3: t num = e2.q
    logic signed [EW-1:0]  opa [4][3];
    logic signed [HW-1:0]  opb [4][3];
    logic signed [LOW-1:0] lo_s3_reg [4][3];
    logic signed [HIW-1:0] hi_s3_reg [4][3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            opa[0][j] = e1_s2_reg[j];
            opb[0][j] = h_s2_reg[j];
            opa[1][j] = sv_s2_reg[j];
            opb[1][j] = h_s2_reg[j];
            opa[2][j] = dir_e[j];
            opb[2][j] = q_s2_reg[j];
            opa[3][j] = e2_s2_reg[j];
            opb[3][j] = q_s2_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_rdy[3]) begin
            for (int k = 0; k < 4; k++) begin
                for (int j = 0; j < 3; j++) begin
                    lo_s3_reg[k][j] <= opa[k][j] * $signed({1'b0, opb[k][j][SPL-1:0]});
                    hi_s3_reg[k][j] <= opa[k][j] * $signed(opb[k][j][HW-1:SPL]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: recombine partial products
    logic signed [DOTW-1:0] term_s4_reg [4][3];

    always_ff @(posedge aclk) begin
        if (stage_rdy[4]) begin
            for (int k = 0; k < 4; k++) begin
                for (int j = 0; j < 3; j++) begin
                    term_s4_reg[k][j] <= (DOTW'(hi_s3_reg[k][j]) <<< SPL)
                                         + DOTW'(lo_s3_reg[k][j]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: dot product sums
    logic signed [DOTW-1:0] dot_s5_reg [4];

    always_ff @(posedge aclk) begin
        if (stage_rdy[5]) begin
            for (int k = 0; k < 4; k++) begin
                dot_s5_reg[k] <= term_s4_reg[k][0] + term_s4_reg[k][1] + term_s4_reg[k][2];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: magnitudes and quotient signs
    logic [DOTW-1:0] den_s6_reg;
    logic [NW-1:0]   num_s6_reg [3];
    logic            neg_s6_reg [3];

    always_ff @(posedge aclk) begin
        if (stage_rdy[6]) begin
            den_s6_reg <= dot_s5_reg[0][DOTW-1] ? DOTW'(-dot_s5_reg[0])
                                                : DOTW'(dot_s5_reg[0]);
            for (int k = 0; k < 3; k++) begin
                num_s6_reg[k] <= (dot_s5_reg[k+1][DOTW-1] ? NW'(DOTW'(-dot_s5_reg[k+1]))
                                                          : NW'(DOTW'(dot_s5_reg[k+1])))
                                 << FRAC_BITS;
                neg_s6_reg[k] <= dot_s5_reg[k+1][DOTW-1] ^ dot_s5_reg[0][DOTW-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: parallel test and quotient overflow detection
    logic            par_s7_reg;
    logic [DOTW-1:0] den_s7_reg;
    logic [NW-1:0]   num_s7_reg [3];
    logic            neg_s7_reg [3];
    logic            ovf_s7_reg [3];

    always_ff @(posedge aclk) begin
        if (stage_rdy[7]) begin
            par_s7_reg <= (den_s6_reg == '0)
                          || (den_s6_reg < (DOTW'(epsilon_reg) << (2 * FRAC_BITS)));
            den_s7_reg <= den_s6_reg;
            for (int k = 0; k < 3; k++) begin
                num_s7_reg[k] <= num_s6_reg[k];
                neg_s7_reg[k] <= neg_s6_reg[k];
                ovf_s7_reg[k] <= DOTW'(num_s6_reg[k][NW-1:QW]) >= den_s6_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Dividers for u, v and t, with the parallel flag traveling alongside
    logic [QW-1:0] quo_q   [3];
    logic          quo_neg [3];
    logic          quo_ovf [3];
    logic          par_pipe_reg [QW];

    for (genvar n = 0; n < 3; n++) begin : g_div
        rti_div_pipe #(
            .NW (NW),
            .DW (DOTW),
            .QW (QW)
        ) u_div (
            .aclk  (aclk),
            .en    (stage_rdy[PRE +: QW]),
            .num_i (num_s7_reg[n]),
            .den_i (den_s7_reg),
            .neg_i (neg_s7_reg[n]),
            .ovf_i (ovf_s7_reg[n]),
            .q_o   (quo_q[n]),
            .neg_o (quo_neg[n]),
            .ovf_o (quo_ovf[n])
        );
    end

    always_ff @(posedge aclk) begin
        if (stage_rdy[PRE]) begin
            par_pipe_reg[0] <= par_s7_reg;
        end
        for (int k = 1; k < QW; k++) begin
            if (stage_rdy[PRE+k]) begin
                par_pipe_reg[k] <= par_pipe_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result stage: clamp magnitude, apply sign
    logic signed [RW-1:0] res_next [3];
    logic signed [RW-1:0] res_s8_reg [3];
    logic                 par_s8_reg;

    always_comb begin
        for (int n = 0; n < 3; n++) begin
            logic [QW-1:0]        mag;
            logic signed [RW-1:0] smag;
            mag  = (quo_ovf[n] || (quo_q[n] > QCLAMP)) ? QCLAMP : quo_q[n];
            smag = $signed({1'b0, mag});
            res_next[n] = quo_neg[n] ? -smag : smag;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_rdy[ST_RES]) begin
            res_s8_reg <= res_next;
            par_s8_reg <= par_pipe_reg[QW-1];
        end
    end

    // ------------------------------------------------------------------
    // Check stage: range tests, reason, dir * t products
    miss_reason_t         reason_next;
    logic signed [RW:0]   uv_sum;
    miss_reason_t         reason_s9_reg;
    logic [30:0]          t_s9_reg;
    logic signed [MW-1:0] prod_s9_reg [3];

    always_comb begin
        uv_sum = (RW+1)'(res_s8_reg[0]) + (RW+1)'(res_s8_reg[1]);
        if (par_s8_reg) begin
            reason_next = REASON_PARALLEL;
        end else if (res_s8_reg[0] < 0 || res_s8_reg[0] > ONE_Q) begin
            reason_next = REASON_U_OUT;
        end else if (res_s8_reg[1] < 0 || uv_sum > (RW+1)'(ONE_Q)) begin
            reason_next = REASON_V_OUT;
        end else if (!(res_s8_reg[2] > $signed(RW'(epsilon_reg))
                       && res_s8_reg[2] < $signed(RW'(max_distance_reg)))) begin
            reason_next = REASON_DIST_OUT;
        end else begin
            reason_next = REASON_HIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_rdy[ST_CHK]) begin
            reason_s9_reg <= reason_next;
            t_s9_reg      <= res_s8_reg[2][30:0];
            for (int i = 0; i < 3; i++) begin
                prod_s9_reg[i] <= dir_reg[i] * $signed({1'b0, res_s8_reg[2][30:0]});
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: floor, add origin, saturate; zeros on a miss
    logic signed [SUMW-1:0] pt_sum [3];
    logic signed [CW-1:0]   pt_next [3];
    logic                   hit_next;

    logic                   m_hit_reg;
    miss_reason_t           m_reason_reg;
    logic [30:0]            m_distance_reg;
    logic signed [CW-1:0]   m_point_reg [3];

    assign hit_next = (reason_s9_reg == REASON_HIT);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pt_sum[i] = SUMW'(origin_reg[i]) + SUMW'(prod_s9_reg[i] >>> FRAC_BITS);
            if (!hit_next) begin
                pt_next[i] = '0;
            end else if (pt_sum[i] > SAT_MAX) begin
                pt_next[i] = SAT_MAX[CW-1:0];
            end else if (pt_sum[i] < SAT_MIN) begin
                pt_next[i] = SAT_MIN[CW-1:0];
            end else begin
                pt_next[i] = pt_sum[i][CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_rdy[ST_OUT]) begin
            m_hit_reg      <= hit_next;
            m_reason_reg   <= reason_s9_reg;
            m_distance_reg <= hit_next ? t_s9_reg : '0;
            m_point_reg    <= pt_next;
        end
    end

    assign m_hit         = m_hit_reg;
    assign m_miss_reason = m_reason_reg;
    assign m_distance    = m_distance_reg;
    assign m_point_x     = m_point_reg[0];
    assign m_point_y     = m_point_reg[1];
    assign m_point_z     = m_point_reg[2];

    // ------------------------------------------------------------------
    // Assertions

    // Input stalls only when the whole pipeline is full and output is blocked
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&valid_reg && !m_ready))
        else $error("input stalled with a free pipeline stage");

    // Hit flag agrees with reason code
    a_hit_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hit == (m_miss_reason == REASON_HIT)))
        else $error("hit flag and reason code disagree");

    // A miss carries zeroed distance and point
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_distance == '0 && m_point_x == '0
                                 && m_point_y == '0 && m_point_z == '0))
        else $error("miss result with nonzero payload");

    // A hit distance lies strictly inside the configured range
    a_hit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit) |-> (m_distance > 31'(epsilon_reg)
                                && m_distance < max_distance_reg))
        else $error("hit distance outside range");

endmodule

`default_nettype wire
